[rtl/bpfa_pkg.sv]
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types, codes and helpers of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  // field widths
  localparam int ACTION_W = 2;
  localparam int PAGE_W   = 12;
  localparam int RUN_W    = 13;
  localparam int LIMIT_W  = 13;
  localparam int COUNT_W  = 13;

  // map rows: one ram word holds the used bits of 32 pages
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  localparam int ROW_W  = LIMIT_W - BIT_W;

  // defaults
  localparam int NUM_PAGES_DEFAULT = 4096;
  localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RESET = LIMIT_W'(4096);

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_PAGE_LIMIT = 1'b0;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RETURN  = 2'd2;

  // status codes
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_NO_PAGE = 1'b1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PAGE_W-1:0]   page_number;
    logic [RUN_W-1:0]    run_length;
  } req_item_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  allocated_page;
    logic               status;
    logic [COUNT_W-1:0] free_pages;
  } rsp_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } seq_state_t;

  // index of the lowest set bit, binary search in five steps
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    logic [BIT_W-1:0]  idx;
    v   = w;
    idx = '0;
    for (int k = BIT_W - 1; k >= 0; k--) begin
      if ((v & ((WORD_W'(1) << (1 << k)) - WORD_W'(1))) == '0) begin
        idx[k] = 1'b1;
        v      = v >> (1 << k);
      end
    end
    return idx;
  endfunction

endpackage

[rtl/bpfa_ram.sv]
// ----------------------------------------------------------------------------
// bpfa_ram
// Simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/bitmap_page_frame_allocator_top.sv]
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_top
// Page allocator over a one-bit-per-page used map held in ram.
// ----------------------------------------------------------------------------
// The used map lives in a ram of 32-bit rows (32 pages per row) with a
// registered read; every item is a read-modify-write sequence over those
// rows, one row per cycle, and only one item is in work at a time. Allocate
// scans rows from the hint up to the first free page or the limit; reserve
// and return walk the rows that the clipped run touches; an empty run or
// unused action code goes straight to the result. One more item is accepted
// while a finished result still waits in the output register. After reset
// every page reads as used through per-row valid bits that reset clears at
// once, so there is no clearing pass and items are taken from the first
// cycle. page_limit is written over the apb port at byte address 0 and reads
// back there; write it only while idle.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_top #(
  parameter int NUM_PAGES = bpfa_pkg::NUM_PAGES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         req_valid,
  output logic                         req_ready,
  input  bpfa_pkg::req_item_t          req,
  // response channel
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output bpfa_pkg::rsp_item_t          rsp,
  // apb configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpfa_pkg::PADDR_W-1:0] paddr,
  input  logic [bpfa_pkg::PDATA_W-1:0] pwdata,
  output logic [bpfa_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  import bpfa_pkg::*;

  // pages above the 13-bit limit are never reached, so at most 256 rows exist
  localparam int WORDS    = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int RAM_ROWS = (WORDS < (1 << ROW_W)) ? WORDS : (1 << ROW_W);
  localparam int RA_W     = (RAM_ROWS > 1) ? $clog2(RAM_ROWS) : 1;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP =
    (NUM_PAGES >= (1 << LIMIT_W) - 1) ? LIMIT_W'((1 << LIMIT_W) - 1) : LIMIT_W'(NUM_PAGES);
  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
  localparam logic [WORD_W-1:0] ONE      = WORD_W'(1);

  // state
  seq_state_t state, state_next;
  logic [LIMIT_W-1:0] page_limit;
  logic [LIMIT_W-1:0] hint, hint_next;
  logic [COUNT_W-1:0] free_count, count_next;
  logic [RAM_ROWS-1:0] row_valid;

  // item context
  logic [ACTION_W-1:0] op;
  logic [ROW_W-1:0]    row;
  logic [ROW_W-1:0]    last_row;
  logic [LIMIT_W-1:0]  lo;
  logic [LIMIT_W-1:0]  hi;
  logic [PAGE_W-1:0]   res_page;
  logic                res_status;

  // changed bits of the last written run row, folded in on the cycle after
  logic                chg_v;
  logic [WORD_W-1:0]   chg_q;
  logic [ROW_W-1:0]    chg_row;

  // ram side
  logic                ram_we, ram_re;
  logic [RA_W-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;
  logic [ROW_W-1:0]    rd_row;
  logic                rd_vld;

  // combinational
  logic               accept;
  logic [LIMIT_W-1:0] lim;
  logic [LIMIT_W:0]   run_end;
  logic [LIMIT_W-1:0] run_hi, run_hi_m1;
  logic               run_empty, alloc_empty;
  logic [WORD_W-1:0]  word, lo_mask, hi_mask, span, free_bits, chg_bits, run_word;
  logic [LIMIT_W-1:0] lo_page, hi_page;
  logic               found, scan_end, last;
  logic [BIT_W-1:0]   free_idx;
  logic [LIMIT_W-1:0] found_page;
  logic [ROW_W:0]     row_up;
  logic [LIMIT_W:0]   next_base;
  logic [COUNT_W-1:0] pop;
  logic [LIMIT_W-1:0] chg_page;
  logic               done_fire;

  bpfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective limit, clamped to the map size
  assign lim = (page_limit < LIMIT_CAP) ? page_limit : LIMIT_CAP;

  assign accept    = req_valid && req_ready;
  assign done_fire = (state == ST_DONE) && (!rsp_valid || rsp_ready);

  // run clipped to the limit
  assign run_end     = {2'b00, req.page_number} + {1'b0, req.run_length};
  assign run_hi      = (run_end < {1'b0, lim}) ? run_end[LIMIT_W-1:0] : lim;
  assign run_hi_m1   = run_hi - 1'b1;
  assign run_empty   = {1'b0, req.page_number} >= run_hi;
  assign alloc_empty = hint >= lim;

  // row that just came out of the ram; a row never written reads as all used
  assign word = rd_vld ? ram_rdata : ALL_ONES;

  // pages of this row inside [lo_page, hi_page)
  assign lo_page = (state == ST_SCAN) ? hint : lo;
  assign hi_page = (state == ST_SCAN) ? lim : hi;
  assign lo_mask = (row == lo_page[LIMIT_W-1:BIT_W]) ? (ALL_ONES << lo_page[BIT_W-1:0])
                                                     : ALL_ONES;
  assign hi_mask = (row == hi_page[LIMIT_W-1:BIT_W]) ?
                   ((ONE << hi_page[BIT_W-1:0]) - ONE) : ALL_ONES;
  assign span    = lo_mask & hi_mask;

  // allocate scan
  assign free_bits  = ~word & span;
  assign found      = |free_bits;
  assign free_idx   = lowest_set(free_bits);
  assign found_page = {row, free_idx};
  assign row_up     = {1'b0, row} + 1'b1;
  assign next_base  = {row_up, BIT_W'(0)};
  assign scan_end   = next_base >= {1'b0, lim};

  // reserve sets, return clears
  assign chg_bits = (op == ACT_RESERVE) ? (~word & span) : (word & span);
  assign run_word = (op == ACT_RESERVE) ? (word | span) : (word & ~span);
  assign last     = row == last_row;

  // ---------------------------------------------------------------- fsm
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.action) inside
            ACT_ALLOC:               state_next = alloc_empty ? ST_DONE : ST_SCAN;
            ACT_RESERVE, ACT_RETURN: state_next = run_empty ? ST_DONE : ST_RUN;
            default:                 state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (found || scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_RUN: begin
        if (last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (done_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake and ram control
  always_comb begin
    req_ready = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = word;
    ram_re    = 1'b0;
    rd_row    = row_up[ROW_W-1:0];
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req.action == ACT_ALLOC) begin
          rd_row = hint[LIMIT_W-1:BIT_W];
          ram_re = req_valid && !alloc_empty;
        end else begin
          rd_row = ROW_W'(req.page_number[PAGE_W-1:BIT_W]);
          ram_re = req_valid && !run_empty &&
                   (req.action == ACT_RESERVE || req.action == ACT_RETURN);
        end
      end
      ST_SCAN: begin
        if (found) begin
          ram_we    = 1'b1;
          ram_wdata = word | (ONE << free_idx);
        end else begin
          ram_re = !scan_end;
        end
      end
      ST_RUN: begin
        ram_we    = 1'b1;
        ram_wdata = run_word;
        ram_re    = !last;
      end
      ST_DRAIN, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign ram_waddr = RA_W'(row);
  assign ram_raddr = RA_W'(rd_row);

  // ---------------------------------------------------------------- count and hint
  assign pop      = COUNT_W'($countones(chg_q));
  assign chg_page = {chg_row, lowest_set(chg_q)};

  always_comb begin
    hint_next  = hint;
    count_next = free_count;
    if (chg_v) begin
      if (op == ACT_RESERVE) begin
        count_next = free_count - pop;
      end else begin
        count_next = free_count + pop;
        // rows go upward, so the first changed row holds the lowest page
        if ((chg_q != '0) && (hint > chg_page)) begin
          hint_next = chg_page;
        end
      end
    end
    if (state == ST_SCAN) begin
      if (found) begin
        hint_next  = found_page;
        count_next = free_count - 1'b1;
      end else if (scan_end) begin
        hint_next = lim;
      end
    end
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hint       <= '0;
      free_count <= '0;
      row_valid  <= '0;
      chg_v      <= 1'b0;
      rsp_valid  <= 1'b0;
      page_limit <= PAGE_LIMIT_RESET;
    end else begin
      state      <= state_next;
      hint       <= hint_next;
      free_count <= count_next;
      chg_v      <= (state == ST_RUN);
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      if (done_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (psel && penable && pwrite && pready && (paddr[PADDR_W-1] == REG_PAGE_LIMIT)) begin
        page_limit <= pwdata[LIMIT_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vld <= row_valid[ram_raddr];
    end
    if (accept) begin
      op         <= req.action;
      row        <= rd_row;
      lo         <= {1'b0, req.page_number};
      hi         <= run_hi;
      last_row   <= run_hi_m1[LIMIT_W-1:BIT_W];
      res_page   <= '0;
      res_status <= (req.action == ACT_ALLOC && alloc_empty) ? STATUS_NO_PAGE : STATUS_DONE;
    end
    if (state == ST_SCAN) begin
      if (found) begin
        res_page <= found_page[PAGE_W-1:0];
      end else if (scan_end) begin
        res_status <= STATUS_NO_PAGE;
      end else begin
        row <= row_up[ROW_W-1:0];
      end
    end
    if (state == ST_RUN) begin
      chg_q   <= chg_bits;
      chg_row <= row;
      row     <= row_up[ROW_W-1:0];
    end
    if (done_fire) begin
      rsp.allocated_page <= res_page;
      rsp.status         <= res_status;
      rsp.free_pages     <= free_count;
    end
  end

  // apb read side
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_PAGE_LIMIT) ? PDATA_W'(page_limit) : '0;

  // ---------------------------------------------------------------- assertions
  // run row changes are folded in only while the run is still in work
  a_chg_in_run: assert property (@(posedge clk) disable iff (rst)
    chg_v |-> (state == ST_RUN || state == ST_DRAIN))
    else $error("row change pending outside a run");

  // a granted page takes exactly one page off the count
  a_grant_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && found) |=> (free_count == $past(free_count) - 1'b1))
    else $error("grant did not decrement free count");

  // read-modify-write never reads the row it is writing
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("ram read and write hit the same row");

  // a failed allocate leaves the hint at or beyond the limit
  a_fail_hint: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_status == STATUS_NO_PAGE) |-> (hint >= lim))
    else $error("failed allocate left hint below limit");

  // out of pages never reports a page
  a_fail_page: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STATUS_NO_PAGE) |-> (rsp.allocated_page == '0))
    else $error("failed allocate reported a page");

endmodule
